@@ rtl/core/akf_pkg.sv @@
// ----------------------------------------------------------------------------
// akf_pkg
// Types, constants and saturating helpers shared by the angle/bias filter core.
// ----------------------------------------------------------------------------
package akf_pkg;

	localparam int SampleWidth   = 32;
	localparam int CfgWidth      = 32;
	localparam int CfgIndexWidth = 3;
	localparam int DataWidth     = 64;
	localparam int ProdWidth     = 2 * DataWidth;
	localparam int DivSteps      = DataWidth + 32;
	localparam int DivCntWidth   = $clog2(DivSteps + 1);

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_ANGLE_NOISE,
		CFG_BIAS_NOISE,
		CFG_MEAS_NOISE,
		CFG_PERIOD
	} akf_cfg_idx_t;

	localparam logic [CfgWidth-1:0] AngleNoiseReset = 32'd4294967;
	localparam logic [CfgWidth-1:0] BiasNoiseReset  = 32'd12884902;
	localparam logic [CfgWidth-1:0] MeasNoiseReset  = 32'd2147483648;
	localparam logic [CfgWidth-1:0] PeriodReset     = 32'd21474836;

	typedef struct packed {
		logic signed [SampleWidth-1:0] measured_angle;
		logic signed [SampleWidth-1:0] gyro_rate;
	} akf_in_t;

	typedef struct packed {
		logic signed [SampleWidth-1:0] angle_estimate;
		logic signed [SampleWidth-1:0] bias_estimate;
	} akf_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} akf_unit_sts_t;

	function automatic logic [DataWidth-1:0] mag(input logic signed [DataWidth-1:0] a);
		mag = a[DataWidth-1] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic signed [DataWidth-1:0] add_sat(
		input logic signed [DataWidth-1:0] a,
		input logic signed [DataWidth-1:0] b
	);
		logic signed [DataWidth-1:0] s;
		s = a + b;
		if (!a[DataWidth-1] && !b[DataWidth-1] && s[DataWidth-1]) begin
			s = {1'b0, {(DataWidth-1){1'b1}}};
		end else if (a[DataWidth-1] && b[DataWidth-1] && !s[DataWidth-1]) begin
			s = {1'b1, {(DataWidth-1){1'b0}}};
		end
		add_sat = s;
	endfunction

	// clamp to a signed range of w bits
	function automatic logic signed [DataWidth-1:0] sat_to(
		input logic signed [DataWidth-1:0] v,
		input int w
	);
		logic signed [DataWidth-1:0] hi;
		logic signed [DataWidth-1:0] lo;
		hi = signed'((64'd1 << (w - 1)) - 64'd1);
		lo = -hi - 64'sd1;
		if (v > hi) begin
			sat_to = hi;
		end else if (v < lo) begin
			sat_to = lo;
		end else begin
			sat_to = v;
		end
	endfunction

endpackage

@@ rtl/core/akf_mul.sv @@
// ----------------------------------------------------------------------------
// akf_mul
// Iterative signed multiply, result round(a*b / 2^32) with saturation.
// Four 32x32 partial products, one per cycle, then a rounding step.
// ----------------------------------------------------------------------------
module akf_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [akf_pkg::DataWidth-1:0] a,
	input  logic signed [akf_pkg::DataWidth-1:0] b,
	output akf_pkg::akf_unit_sts_t            sts,
	output logic signed [akf_pkg::DataWidth-1:0] result
);
	import akf_pkg::*;

	logic [DataWidth-1:0] ua_q;
	logic [DataWidth-1:0] ub_q;
	logic                 neg_q;
	logic [ProdWidth-1:0] acc_q;
	logic [2:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [DataWidth-1:0] result_q;

	logic [63:0]          pp;
	logic [ProdWidth-1:0] pp_shift;
	logic [1:0]           sh;
	logic [ProdWidth-1:0] rnd;
	logic [DataWidth-1:0] mag_r;

	always_comb begin
		pp  = 64'(ua_q[{cnt_q[1], 5'b0} +: 32]) * 64'(ub_q[{cnt_q[0], 5'b0} +: 32]);
		sh  = 2'(cnt_q[1]) + 2'(cnt_q[0]);
		unique case (sh)
			2'd0:    pp_shift = {64'b0, pp};
			2'd1:    pp_shift = {32'b0, pp, 32'b0};
			2'd2:    pp_shift = {pp, 64'b0};
			default: pp_shift = '0;
		endcase
		rnd = acc_q + 128'h8000_0000;
		// anything at or above bit 95 would not fit in 63 magnitude bits
		mag_r = (|rnd[ProdWidth-1:95]) ? {1'b0, {(DataWidth-1){1'b1}}} : {1'b0, rnd[94:32]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ua_q   <= mag(a);
				ub_q   <= mag(b);
				neg_q  <= a[DataWidth-1] ^ b[DataWidth-1];
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q[2]) begin
					result_q <= neg_q ? -signed'(mag_r) : signed'(mag_r);
					done_q   <= 1'b1;
					busy_q   <= 1'b0;
				end else begin
					acc_q <= acc_q + pp_shift;
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = result_q;

endmodule

@@ rtl/core/akf_div.sv @@
// ----------------------------------------------------------------------------
// akf_div
// Bit-serial gain divider: num / den in Q16.32, truncated toward zero,
// clamped to the covariance range, zero for a zero denominator.
// ----------------------------------------------------------------------------
module akf_div #(
	parameter int COV_WIDTH = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [akf_pkg::DataWidth-1:0] num,
	input  logic signed [akf_pkg::DataWidth-1:0] den,
	output akf_pkg::akf_unit_sts_t            sts,
	output logic signed [akf_pkg::DataWidth-1:0] result
);
	import akf_pkg::*;

	localparam logic [DivSteps-1:0] Cap = DivSteps'((64'd1 << (COV_WIDTH - 1)) - 64'd1);

	logic [DivSteps-1:0]    dq_q;
	logic [DataWidth-1:0]   r_q;
	logic [DataWidth-1:0]   ud_q;
	logic                   neg_q;
	logic                   zero_q;
	logic [DivCntWidth-1:0] cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic signed [DataWidth-1:0] result_q;

	logic [DataWidth:0]   rs;
	logic [DataWidth:0]   diff;
	logic                 ge;
	logic [DivSteps-1:0]  q_sat;

	always_comb begin
		rs    = {r_q, dq_q[DivSteps-1]};
		diff  = rs - {1'b0, ud_q};
		ge    = (rs >= {1'b0, ud_q});
		q_sat = (dq_q > Cap) ? Cap : dq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dq_q   <= {mag(num), 32'b0};
				r_q    <= '0;
				ud_q   <= mag(den);
				zero_q <= (den == '0);
				neg_q  <= num[DataWidth-1] ^ den[DataWidth-1];
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == DivCntWidth'(DivSteps)) begin
					if (zero_q) begin
						result_q <= '0;
					end else if (neg_q) begin
						result_q <= -signed'(q_sat[DataWidth-1:0]);
					end else begin
						result_q <= signed'(q_sat[DataWidth-1:0]);
					end
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					r_q   <= ge ? diff[DataWidth-1:0] : rs[DataWidth-1:0];
					dq_q  <= {dq_q[DivSteps-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = result_q;

endmodule

@@ rtl/core/angle_gyro_bias_kalman_filter_core.sv @@
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_filter_core
// Two-state angle / gyro bias Kalman filter in fixed point.
//
// Input beats carry a measured angle and a gyro rate (signed Q16.16); each
// one yields an output beat with the corrected angle and bias (Q16.16,
// saturated). Four Q0.32 registers (angle noise, bias noise, measurement
// noise, sample period) are written through the cfg port; the user must
// write them only while idle, the core itself does not enforce this.
// A small sequencer runs every product through one iterative multiplier
// (ten products per sample) and both gains through one bit-serial divider.
// in_stall is high from the accepting edge until the sequencer returns to
// idle, so a new sample is not taken while the last one is in work.
// The result sits in an output register, so a new sample is taken while the
// last one waits; a finished sample waits for the output register to free
// up if out_stall holds it. Reset sets angle and bias to zero, the
// covariance to identity and the registers to their defaults.
// ----------------------------------------------------------------------------
module angle_gyro_bias_kalman_filter_core #(
	parameter int COV_WIDTH = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  akf_pkg::akf_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output akf_pkg::akf_out_t                    out_data,
	input  logic                                 cfg_we,
	input  logic [akf_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  logic [akf_pkg::CfgWidth-1:0]         cfg_data
);
	import akf_pkg::*;

	localparam logic signed [COV_WIDTH-1:0] CovOne =
		COV_WIDTH'(sat_to(64'sd1 <<< 32, COV_WIDTH));

	typedef enum logic [3:0] {
		S_IDLE, S_M_ANG, S_M_T1, S_M_T2, S_M_T3, S_PRED, S_SUM, S_D_K1, S_D_K2,
		S_M_A, S_M_B, S_M_PAA, S_M_PAB, S_M_PBA, S_M_PBB, S_OUT
	} state_t;

	state_t state_q;
	logic   launched_q;

	logic [CfgWidth-1:0] angle_noise_q, bias_noise_q, meas_noise_q, period_q;

	logic signed [SampleWidth-1:0] angle_q, bias_q, meas_q, rate_q, ang_q;
	logic signed [COV_WIDTH-1:0]   paa_q, pab_q, pba_q, pbb_q;
	logic signed [COV_WIDTH-1:0]   p00_q, p01_q, p10_q, p11_q;
	logic signed [DataWidth-1:0]   t1_q, t2_q, t3_q, s_q, k1_q, k2_q;

	logic     out_valid_q;
	akf_out_t out_data_q;

	logic signed [DataWidth-1:0] angle_x, bias_x, meas_x, rate_x, ang_x;
	logic signed [DataWidth-1:0] paa_x, pab_x, pba_x, pbb_x, p00_x, p01_x, p10_x, p11_x;
	logic signed [DataWidth-1:0] dt_x, innov, p00_pred;
	logic signed [DataWidth-1:0] mul_a, mul_b, mul_res, div_res;
	logic                        mul_start, div_start, is_mul;
	akf_unit_sts_t               mul_sts, div_sts;

	always_comb begin
		angle_x = angle_q;
		bias_x  = bias_q;
		meas_x  = meas_q;
		rate_x  = rate_q;
		ang_x   = ang_q;
		paa_x   = paa_q;
		pab_x   = pab_q;
		pba_x   = pba_q;
		pbb_x   = pbb_q;
		p00_x   = p00_q;
		p01_x   = p01_q;
		p10_x   = p10_q;
		p11_x   = p11_q;
		dt_x    = signed'({32'b0, period_q});
		innov   = meas_x - ang_x;
		p00_pred = add_sat(add_sat(paa_x, -t1_q), t3_q);
		p00_pred = sat_to(add_sat(p00_pred, signed'({32'b0, angle_noise_q})), COV_WIDTH);

		is_mul = 1'b1;
		mul_a  = k1_q;
		mul_b  = innov;
		unique case (state_q)
			S_M_ANG: begin
				mul_a = rate_x - bias_x;
				mul_b = dt_x;
			end
			S_M_T1: begin
				mul_a = add_sat(pab_x, pba_x);
				mul_b = dt_x;
			end
			S_M_T2: begin
				mul_a = pbb_x;
				mul_b = dt_x;
			end
			S_M_T3: begin
				mul_a = t2_q;
				mul_b = dt_x;
			end
			S_M_A: begin
				mul_a = k1_q;
				mul_b = innov;
			end
			S_M_B: begin
				mul_a = k2_q;
				mul_b = innov;
			end
			S_M_PAA: begin
				mul_a = k1_q;
				mul_b = p00_x;
			end
			S_M_PAB: begin
				mul_a = k1_q;
				mul_b = p01_x;
			end
			S_M_PBA: begin
				mul_a = k2_q;
				mul_b = p00_x;
			end
			S_M_PBB: begin
				mul_a = k2_q;
				mul_b = p01_x;
			end
			default: is_mul = 1'b0;
		endcase
		mul_start = is_mul && !launched_q;
		div_start = (state_q == S_D_K1 || state_q == S_D_K2) && !launched_q;
	end

	akf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sts    (mul_sts),
		.result (mul_res)
	);

	akf_div #(
		.COV_WIDTH (COV_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ((state_q == S_D_K2) ? p10_x : p00_x),
		.den    (s_q),
		.sts    (div_sts),
		.result (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			launched_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			angle_noise_q <= AngleNoiseReset;
			bias_noise_q  <= BiasNoiseReset;
			meas_noise_q  <= MeasNoiseReset;
			period_q      <= PeriodReset;
			angle_q       <= '0;
			bias_q        <= '0;
			paa_q         <= CovOne;
			pab_q         <= '0;
			pba_q         <= '0;
			pbb_q         <= CovOne;
		end else begin
			// in S_OUT the output register is reloaded below instead
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ANGLE_NOISE: angle_noise_q <= cfg_data;
					CFG_BIAS_NOISE:  bias_noise_q  <= cfg_data;
					CFG_MEAS_NOISE:  meas_noise_q  <= cfg_data;
					CFG_PERIOD:      period_q      <= cfg_data;
					default: ;
				endcase
			end
			if (mul_start || div_start) begin
				launched_q <= 1'b1;
			end
			if (mul_sts.done || div_sts.done) begin
				launched_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						meas_q  <= in_data.measured_angle;
						rate_q  <= in_data.gyro_rate;
						state_q <= S_M_ANG;
					end
				end
				S_M_ANG: begin
					if (mul_sts.done) begin
						ang_q <= SampleWidth'(sat_to(add_sat(angle_x, mul_res), SampleWidth));
						state_q <= S_M_T1;
					end
				end
				S_M_T1: begin
					if (mul_sts.done) begin
						t1_q    <= mul_res;
						state_q <= S_M_T2;
					end
				end
				S_M_T2: begin
					if (mul_sts.done) begin
						t2_q    <= mul_res;
						state_q <= S_M_T3;
					end
				end
				S_M_T3: begin
					if (mul_sts.done) begin
						t3_q    <= mul_res;
						state_q <= S_PRED;
					end
				end
				S_PRED: begin
					p00_q <= COV_WIDTH'(p00_pred);
					p01_q <= COV_WIDTH'(sat_to(add_sat(pab_x, -t2_q), COV_WIDTH));
					p10_q <= COV_WIDTH'(sat_to(add_sat(pba_x, -t2_q), COV_WIDTH));
					p11_q <= COV_WIDTH'(sat_to(add_sat(pbb_x,
						signed'({32'b0, bias_noise_q})), COV_WIDTH));
					state_q <= S_SUM;
				end
				S_SUM: begin
					s_q     <= add_sat(p00_x, signed'({32'b0, meas_noise_q}));
					state_q <= S_D_K1;
				end
				S_D_K1: begin
					if (div_sts.done) begin
						k1_q    <= div_res;
						state_q <= S_D_K2;
					end
				end
				S_D_K2: begin
					if (div_sts.done) begin
						k2_q    <= div_res;
						state_q <= S_M_A;
					end
				end
				S_M_A: begin
					if (mul_sts.done) begin
						angle_q <= SampleWidth'(sat_to(add_sat(ang_x, mul_res), SampleWidth));
						state_q <= S_M_B;
					end
				end
				S_M_B: begin
					if (mul_sts.done) begin
						bias_q  <= SampleWidth'(sat_to(add_sat(bias_x, mul_res), SampleWidth));
						state_q <= S_M_PAA;
					end
				end
				S_M_PAA: begin
					if (mul_sts.done) begin
						paa_q   <= COV_WIDTH'(sat_to(add_sat(p00_x, -mul_res), COV_WIDTH));
						state_q <= S_M_PAB;
					end
				end
				S_M_PAB: begin
					if (mul_sts.done) begin
						pab_q   <= COV_WIDTH'(sat_to(add_sat(p01_x, -mul_res), COV_WIDTH));
						state_q <= S_M_PBA;
					end
				end
				S_M_PBA: begin
					if (mul_sts.done) begin
						pba_q   <= COV_WIDTH'(sat_to(add_sat(p10_x, -mul_res), COV_WIDTH));
						state_q <= S_M_PBB;
					end
				end
				S_M_PBB: begin
					if (mul_sts.done) begin
						pbb_q   <= COV_WIDTH'(sat_to(add_sat(p11_x, -mul_res), COV_WIDTH));
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q               <= 1'b1;
						out_data_q.angle_estimate <= angle_q;
						out_data_q.bias_estimate  <= bias_q;
						state_q                   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_sts.busy)
		else $error("multiplier started while busy");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && out_stall) |=> (state_q == S_OUT))
		else $error("result dropped while output register full");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sample accepted without starting work");

endmodule
